// ----- rtl/djs_pkg.sv -----
`timescale 1ns / 1ps
package djs_pkg;
  localparam int MAX_JOBS = 256;
  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int DL_W = CNT_W;
  localparam int PROF_W = 16;
  localparam int DONE_W = 9;
  localparam int SUM_W = 24;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [DL_W-1:0]   dl;
    logic [PROF_W-1:0] prof;
    logic              keep;
    logic              last;
  } job_t;
endpackage

// ----- rtl/djs_front.sv -----
`timescale 1ns / 1ps
// clamps deadline and marks jobs that overflow the store
module djs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic [15:0]       deadline,
  input  logic [15:0]       profit,
  input  logic              last,
  output logic              q_valid,
  input  logic              q_stall,
  output djs_pkg::job_t     q_data
);
  logic [djs_pkg::CNT_W-1:0] seen;
  djs_pkg::job_t mem [djs_pkg::QDEPTH];
  logic [djs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [djs_pkg::QPTR_W:0] fill;
  logic push, pop;
  djs_pkg::job_t job;

  assign stall = (fill == (djs_pkg::QPTR_W+1)'(djs_pkg::QDEPTH));
  assign push = valid && !stall;
  assign q_valid = (fill != '0);
  assign pop = q_valid && !q_stall;
  assign q_data = mem[rd_ptr];

  always_comb begin
    job.dl = (deadline > 16'(djs_pkg::MAX_JOBS)) ? djs_pkg::DL_W'(djs_pkg::MAX_JOBS)
                                                 : djs_pkg::DL_W'(deadline);
    job.prof = profit;
    job.keep = (seen < djs_pkg::CNT_W'(djs_pkg::MAX_JOBS));
    job.last = last;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= job;
    if (rst) begin
      seen <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        if (last) seen <= '0;
        else if (job.keep) seen <= seen + 1'b1;
      end
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (djs_pkg::QPTR_W+1)'(push) - (djs_pkg::QPTR_W+1)'(pop);
    end
  end
endmodule

// ----- rtl/djs_back.sv -----
`timescale 1ns / 1ps
// stores a set, then schedules it greedily: each round scans the stored jobs for
// the next one in falling profit order, then walks slots down from its deadline
module djs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_stall,
  input  djs_pkg::job_t             q_data,
  output logic                      valid,
  input  logic                      stall,
  output logic [djs_pkg::DONE_W-1:0] jobs_done,
  output logic [djs_pkg::SUM_W-1:0]  total_profit
);
  typedef enum logic [2:0] {CLR, LOAD, PICK, SEL, SLOT_RD, SLOT_CHK, DONE} state_t;
  state_t state;

  logic [djs_pkg::DL_W-1:0]   dl_mem [djs_pkg::MAX_JOBS];
  logic [djs_pkg::PROF_W-1:0] pr_mem [djs_pkg::MAX_JOBS];
  logic                       slot_mem [djs_pkg::MAX_JOBS];
  logic [djs_pkg::CNT_W-1:0] n, scan;
  logic [djs_pkg::IDX_W-1:0] best, prev_i, rd_idx, clr_idx, s_addr;
  logic [djs_pkg::PROF_W-1:0] best_p, prev_p, rd_pr;
  logic [djs_pkg::DL_W-1:0] best_dl, rd_dl, s, s_m1;
  logic best_ok, have_prev, rd_ok, slot_rd, elig, take, load_en, mark_en;

  assign q_stall = (state != LOAD);
  assign load_en = (state == LOAD) && q_valid && q_data.keep;
  assign s_m1 = s - 1'b1;
  assign s_addr = s_m1[djs_pkg::IDX_W-1:0];
  assign mark_en = (state == SLOT_CHK) && !slot_rd;
  // next in order: lower profit, or equal profit and later arrival
  assign elig = !have_prev || (rd_pr < prev_p) || (rd_pr == prev_p && rd_idx > prev_i);
  // strict > keeps arrival order on ties
  assign take = rd_ok && elig && (!best_ok || rd_pr > best_p);

  always_ff @(posedge clk) begin
    if (load_en) begin
      dl_mem[n[djs_pkg::IDX_W-1:0]] <= q_data.dl;
      pr_mem[n[djs_pkg::IDX_W-1:0]] <= q_data.prof;
    end
    rd_dl <= dl_mem[scan[djs_pkg::IDX_W-1:0]];
    rd_pr <= pr_mem[scan[djs_pkg::IDX_W-1:0]];
    rd_idx <= scan[djs_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == CLR) slot_mem[clr_idx] <= 1'b0;
    else if (mark_en) slot_mem[s_addr] <= 1'b1;
    slot_rd <= slot_mem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR;
      clr_idx <= '0;
      n <= '0;
      scan <= '0;
      s <= '0;
      rd_ok <= 1'b0;
      best_ok <= 1'b0;
      have_prev <= 1'b0;
      valid <= 1'b0;
      jobs_done <= '0;
      total_profit <= '0;
    end else begin
      case (state)
        CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) state <= LOAD;
        end
        LOAD: if (q_valid) begin
          if (q_data.keep) n <= n + 1'b1;
          if (q_data.last) begin
            state <= PICK;
            scan <= '0;
            rd_ok <= 1'b0;
            best_ok <= 1'b0;
            have_prev <= 1'b0;
            jobs_done <= '0;
            total_profit <= '0;
          end
        end
        PICK: begin
          // registered read, data for scan-1 is checked here
          if (take) begin
            best <= rd_idx;
            best_p <= rd_pr;
            best_dl <= rd_dl;
            best_ok <= 1'b1;
          end
          if (scan == n) begin
            rd_ok <= 1'b0;
            state <= SEL;
          end else begin
            rd_ok <= 1'b1;
            scan <= scan + 1'b1;
          end
        end
        SEL: begin
          if (!best_ok) begin
            // every job has had its turn
            valid <= 1'b1;
            state <= DONE;
          end else begin
            prev_p <= best_p;
            prev_i <= best;
            have_prev <= 1'b1;
            s <= best_dl;
            if (best_dl == '0) begin
              scan <= '0;
              best_ok <= 1'b0;
              state <= PICK;
            end else begin
              state <= SLOT_RD;
            end
          end
        end
        SLOT_RD: state <= SLOT_CHK;
        SLOT_CHK: begin
          if (!slot_rd) begin
            jobs_done <= jobs_done + 1'b1;
            total_profit <= total_profit + djs_pkg::SUM_W'(best_p);
          end
          if (!slot_rd || s == djs_pkg::DL_W'(1)) begin
            scan <= '0;
            best_ok <= 1'b0;
            state <= PICK;
          end else begin
            s <= s_m1;
            state <= SLOT_RD;
          end
        end
        DONE: if (!stall) begin
          valid <= 1'b0;
          n <= '0;
          state <= CLR;
        end
        default: state <= CLR;
      endcase
    end
  end
endmodule

// ----- rtl/deadline_job_sequencer_unit.sv -----
`timescale 1ns / 1ps
// channel | handshake            | fields                  | direction
// job     | valid, stall         | deadline, profit, last  | in
// result  | out_valid, out_stall | jobs_done, total_profit | out
// jobs load one per cycle, unless stalled, through a four-entry queue into the job store.
// after the last job, each round scans the n stored jobs for the next by falling
// profit, then probes slots down from its deadline, reading then checking each slot;
// there are n+1 rounds, the last finding no job left.
// reset is synchronous; a pass over all 256 slots clears the slot map after reset and after
// each result is taken. a stalled result holds; input stalls once the queue is full.
module deadline_job_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [15:0] deadline,
  input  logic [15:0] profit,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  jobs_done,
  output logic [23:0] total_profit
);
  logic q_valid, q_stall;
  djs_pkg::job_t q_data;

  djs_front u_front (
    .clk, .rst, .valid, .stall, .deadline, .profit, .last,
    .q_valid, .q_stall, .q_data
  );

  djs_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data,
    .valid(out_valid), .stall(out_stall), .jobs_done, .total_profit
  );
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [15:0] dl;
    logic [15:0] prof;
    logic        last;
    bit          typed;
    logic [8:0]  want_done;
    logic [23:0] want_sum;
  } job_row_t;

  typedef struct {
    logic [8:0]  done;
    logic [23:0] sum;
  } sched_result_t;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic [15:0] deadline = '0;
  logic [15:0] profit = '0;
  logic        last = 1'b0;
  logic        out_stall = 1'b0;
  logic        stall;
  logic        out_valid;
  logic [8:0]  jobs_done;
  logic [23:0] total_profit;

  deadline_job_sequencer_unit uut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .deadline(deadline), .profit(profit), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .jobs_done(jobs_done), .total_profit(total_profit)
  );

  always #10 clk = ~clk;

  // predictor state: the jobs of the set being loaded
  int unsigned   set_dl[$];
  int unsigned   set_prof[$];
  sched_result_t pending_results[$];
  int            fail_count = 0;
  int            results_seen = 0;
  int            sets_sent = 0;
  int            jobs_sent = 0;
  longint        cycle_count = 0;
  bit            hold_off = 1'b0;

  function automatic sched_result_t schedule_jobs();
    sched_result_t r;
    int unsigned   ord[$];
    bit            taken[djs_pkg::MAX_JOBS];
    int unsigned   cnt;
    int unsigned   sum;
    int            j;
    int unsigned   s;
    cnt = 0;
    sum = 0;
    foreach (taken[i]) taken[i] = 1'b0;
    // stable: equal profits keep arrival order
    for (int i = 0; i < set_prof.size(); i++) begin
      j = ord.size();
      while (j > 0 && set_prof[ord[j-1]] < set_prof[i]) j--;
      ord.insert(j, i);
    end
    foreach (ord[k]) begin
      s = set_dl[ord[k]];
      while (s > 0) begin
        if (!taken[s-1]) begin
          taken[s-1] = 1'b1;
          if (cnt < 511) cnt++;
          sum += set_prof[ord[k]];
          if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
          break;
        end
        s--;
      end
    end
    r.done = cnt[8:0];
    r.sum = sum[23:0];
    return r;
  endfunction

  function automatic void record_job(logic [15:0] d, logic [15:0] p, logic l);
    if (set_dl.size() < djs_pkg::MAX_JOBS) begin
      set_dl.insert(set_dl.size(), (d > djs_pkg::MAX_JOBS) ? djs_pkg::MAX_JOBS : int'(d));
      set_prof.insert(set_prof.size(), p);
    end
    if (l) begin
      pending_results.insert(pending_results.size(), schedule_jobs());
      set_dl.delete();
      set_prof.delete();
      sets_sent++;
    end
  endfunction

  task automatic send_job(logic [15:0] d, logic [15:0] p, logic l, bit allow_gap);
    int gap;
    gap = allow_gap ? int'($urandom_range(0, 19)) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    deadline <= d;
    profit <= p;
    last <= l;
    @(posedge clk);
    while (stall) @(posedge clk);
    record_job(d, p, l);
    jobs_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    valid <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        // long hold while the sender keeps offering jobs
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        w = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 19));
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
        out_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: jobs_done %0d total_profit %0d",
               jobs_done, total_profit);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (jobs_done !== e.done) begin
          $error("jobs_done expected %0d actual %0d", e.done, jobs_done);
          fail_count++;
        end
        if (total_profit !== e.sum) begin
          $error("total_profit expected %0d actual %0d", e.sum, total_profit);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  job_row_t directed[] = '{
    // single job sets
    '{16'd0, 16'd500, 1'b1, 1'b1, 9'd0, 24'd0},
    '{16'd1, 16'd0, 1'b1, 1'b1, 9'd1, 24'd0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 9'd1, 24'd65535},
    // all deadline 1: only the best fits
    '{16'd1, 16'd10, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd1, 16'd30, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd1, 16'd20, 1'b1, 1'b1, 9'd1, 24'd30},
    // equal profits
    '{16'd2, 16'd7, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd1, 16'd7, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd2, 16'd7, 1'b1, 1'b0, 9'd0, 24'd0},
    // classic example
    '{16'd4, 16'd20, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd1, 16'd10, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd1, 16'd40, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd1, 16'd30, 1'b1, 1'b1, 9'd2, 24'd60},
    // zero deadlines mixed with huge ones
    '{16'd0, 16'hFFFF, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd256, 16'h8000, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'd257, 16'h5555, 1'b0, 1'b0, 9'd0, 24'd0},
    '{16'hAAAA, 16'hAAAA, 1'b1, 1'b0, 9'd0, 24'd0}
  };

  initial begin
    sched_result_t chk;
    int n;
    int big;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].last) begin
        // predictor must agree with the hand-typed rows
        set_dl.insert(set_dl.size(), (directed[i].dl > djs_pkg::MAX_JOBS) ?
                      djs_pkg::MAX_JOBS : int'(directed[i].dl));
        set_prof.insert(set_prof.size(), directed[i].prof);
        chk = schedule_jobs();
        void'(set_dl.pop_back());
        void'(set_prof.pop_back());
        if (directed[i].typed && chk.done !== directed[i].want_done) begin
          $error("row %0d jobs_done expected %0d actual %0d", i,
                 directed[i].want_done, chk.done);
          fail_count++;
        end
        if (directed[i].typed && chk.sum !== directed[i].want_sum) begin
          $error("row %0d total_profit expected %0d actual %0d", i,
                 directed[i].want_sum, chk.sum);
          fail_count++;
        end
      end
      send_job(directed[i].dl, directed[i].prof, directed[i].last, 1'b1);
    end

    // overflowing set: jobs past the store are ignored, last still closes it
    drain();
    for (int i = 0; i < djs_pkg::MAX_JOBS + 5; i++)
      send_job(16'($urandom_range(0, 300)), 16'($urandom),
               i == djs_pkg::MAX_JOBS + 4, 1'b0);

    // receiver holds off while sets keep arriving
    hold_off = 1'b1;
    for (int k = 0; k < 6; k++)
      for (int i = 0; i < 3; i++)
        send_job(16'($urandom_range(0, 4)), 16'($urandom), i == 2, 1'b0);
    drain();

    // random sets, mostly small
    while (jobs_sent < 650) begin
      big = $urandom_range(0, 29);
      n = (big == 0) ? int'($urandom_range(40, 120)) : int'($urandom_range(1, 12));
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: send_job(16'($urandom), 16'($urandom), i == n - 1, 1'b1);
          1: send_job(16'($urandom_range(0, 1)), 16'($urandom_range(0, 3)), i == n - 1,
                      1'b1);
          default: send_job(16'($urandom_range(0, n + 2)), 16'($urandom), i == n - 1,
                            1'b1);
        endcase
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    idle_input();
    drain();
    repeat (400) @(negedge clk);

    $display("sent %0d jobs in %0d sets, checked %0d results", jobs_sent, sets_sent,
             results_seen);
    $display("covered zero and clamped deadlines, ties, overflow and back-pressure");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// ----- deadline_job_sequencer_unit.f -----
rtl/djs_pkg.sv
rtl/djs_front.sv
rtl/djs_back.sv
rtl/deadline_job_sequencer_unit.sv
tb/sv/testbench.sv
